[rtl/core/zz_scan_pkg.sv]
package zz_scan_pkg;

  // matrix geometry and storage
  localparam int unsigned MaxDim    = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned Depth     = MaxDim * MaxDim;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned PosW      = 4;
  localparam int unsigned DimW      = 5;
  localparam int unsigned CountW    = AddrW + 1;

  // configuration port
  localparam int unsigned CfgIdxW   = 2;
  localparam logic [CfgIdxW-1:0] RegNumRows = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNumCols = 2'd1;
  localparam logic [DimW-1:0]    DimReset   = 5'd8;

  // item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindRead  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [3:0]         elem_row;
    logic [3:0]         elem_col;
    logic               last;
  } out_item_t;

  // out-of-range dimensions fold into 1..MaxDim
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage

[rtl/core/zigzag_matrix_scan_buffer.sv]
// a read transfer shows its result in the cycle after it is taken; a write gives no result
// throughput: one item per cycle, set by the single-port store read and the output register
// an item is held off only while the output register holds a result not yet taken
// reset: sizes return to 8 by 8, load index and scan position to the origin, up-right
// the element store is not cleared; entries hold unknown values until written
module zigzag_matrix_scan_buffer import zz_scan_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DimW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  logic [DimW-1:0]      num_rows_q, num_cols_q;
  logic [AddrW-1:0]     load_idx_q, load_idx_d;
  logic [PosW-1:0]      scan_row_q, scan_row_d, scan_col_q, scan_col_d;
  logic                 scan_up_q, scan_up_d;
  logic                 out_valid_q;
  logic [PosW-1:0]      elem_row_q, elem_col_q;
  logic                 last_q;
  logic [DataWidth-1:0] rd_data_q;
  logic [DataWidth-1:0] mem [Depth];

  logic [DimW-1:0]      rows, cols, rows_m1, cols_m1;
  logic [CountW-1:0]    total, load_next;
  logic [PosW-1:0]      cur_row, cur_col;
  logic                 cur_up, at_end, row_last, col_last;
  logic [CountW-1:0]    rd_addr_full;
  logic [AddrW-1:0]     rd_addr;
  logic                 acc, wr_en, rd_en, cfg_hit;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign wr_en      = acc && (in_data_i.kind == KindWrite);
  assign rd_en      = acc && (in_data_i.kind == KindRead);
  assign cfg_hit    = cfg_we_i && (cfg_idx_i == RegNumRows || cfg_idx_i == RegNumCols);

  // effective sizes
  assign rows    = clamp_dim(num_rows_q);
  assign cols    = clamp_dim(num_cols_q);
  assign rows_m1 = rows - DimW'(1);
  assign cols_m1 = cols - DimW'(1);
  assign total   = CountW'(rows) * CountW'(cols);

  // load index advance with wrap
  always_comb begin
    load_next = {1'b0, load_idx_q};
    if (load_next >= total) begin
      load_next = '0;
    end
    load_next = load_next + CountW'(1);
    if (load_next >= total) begin
      load_next = '0;
    end
    load_idx_d = load_next[AddrW-1:0];
  end

  // current scan position, folded back to origin if outside the matrix
  always_comb begin
    cur_row = scan_row_q;
    cur_col = scan_col_q;
    cur_up  = scan_up_q;
    if ({1'b0, scan_row_q} >= rows || {1'b0, scan_col_q} >= cols) begin
      cur_row = '0;
      cur_col = '0;
      cur_up  = 1'b1;
    end
  end

  assign row_last     = ({1'b0, cur_row} == rows_m1);
  assign col_last     = ({1'b0, cur_col} == cols_m1);
  assign at_end       = row_last && col_last;
  assign rd_addr_full = CountW'(cur_row) * CountW'(cols) + CountW'(cur_col);
  assign rd_addr      = rd_addr_full[AddrW-1:0];

  // zigzag step
  always_comb begin
    scan_row_d = cur_row;
    scan_col_d = cur_col;
    scan_up_d  = cur_up;
    if (at_end) begin
      scan_row_d = '0;
      scan_col_d = '0;
      scan_up_d  = 1'b1;
    end else if (cur_up) begin
      if (col_last) begin
        scan_row_d = cur_row + PosW'(1);
        scan_up_d  = 1'b0;
      end else if (cur_row == '0) begin
        scan_col_d = cur_col + PosW'(1);
        scan_up_d  = 1'b0;
      end else begin
        scan_row_d = cur_row - PosW'(1);
        scan_col_d = cur_col + PosW'(1);
      end
    end else begin
      if (row_last) begin
        scan_col_d = cur_col + PosW'(1);
        scan_up_d  = 1'b1;
      end else if (cur_col == '0) begin
        scan_row_d = cur_row + PosW'(1);
        scan_up_d  = 1'b1;
      end else begin
        scan_row_d = cur_row + PosW'(1);
        scan_col_d = cur_col - PosW'(1);
      end
    end
  end

  // element store, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[load_idx_q] <= DataWidth'(in_data_i.write_value);
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // result fields captured with the read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      elem_row_q <= cur_row;
      elem_col_q <= cur_col;
      last_q     <= at_end;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= DimReset;
      num_cols_q  <= DimReset;
      load_idx_q  <= '0;
      scan_row_q  <= '0;
      scan_col_q  <= '0;
      scan_up_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_idx_i == RegNumRows) begin
          num_rows_q <= cfg_wdata_i;
        end else begin
          num_cols_q <= cfg_wdata_i;
        end
        load_idx_q <= '0;
        scan_row_q <= '0;
        scan_col_q <= '0;
        scan_up_q  <= 1'b1;
      end else begin
        if (wr_en) begin
          load_idx_q <= load_idx_d;
        end
        if (rd_en) begin
          scan_row_q <= scan_row_d;
          scan_col_q <= scan_col_d;
          scan_up_q  <= scan_up_d;
        end
      end
    end
  end

  // output
  assign out_valid_o           = out_valid_q;
  assign out_data_o.read_value = signed'(rd_data_q[31:0]);
  assign out_data_o.elem_row   = elem_row_q;
  assign out_data_o.elem_col   = elem_col_q;
  assign out_data_o.last       = last_q;

endmodule

[rtl/core/zz_scan_checker.sv]
module zz_scan_checker import zz_scan_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a read transfer always yields a result next cycle
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.kind == KindRead) |=> out_valid_o)
    else $error("read transfer without result");

  // a write with a free output slot yields nothing
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.kind == KindWrite
     && (!out_valid_o || out_ready_i)) |=> !out_valid_o)
    else $error("write transfer produced a result");

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

endmodule

bind zigzag_matrix_scan_buffer zz_scan_checker u_zz_scan_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
